@@ src/sgcs_pkg.sv @@
// Shared types, constants and sequence tables of the gain calibration sequencer.
// No dependencies; every other file of the block but sgcs_div imports this package.
package sgcs_pkg;

    localparam int TOP_GAIN_INDEX  = 9;
    localparam int BRIGHTNESS_BITS = 8;
    localparam int GAIN_SLOTS      = TOP_GAIN_INDEX + 1;
    localparam int GAIN_W          = $clog2(GAIN_SLOTS);
    localparam int EMIT_W          = $clog2(GAIN_SLOTS + 3);
    localparam int SUM_W           = 40;

    localparam logic [BRIGHTNESS_BITS-1:0] BRIGHT_MAX = '1;
    localparam logic [31:0] REF_Q16 = 32'h0080_0000;
    localparam logic [31:0] QMAX    = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_LIMIT      = 3'd0;
    localparam logic [2:0] CFG_DELAY      = 3'd1;
    localparam logic [2:0] CFG_SEARCH_SMP = 3'd2;
    localparam logic [2:0] CFG_MEAS_SMP   = 3'd3;
    localparam logic [2:0] CFG_SMP_TIME   = 3'd4;
    localparam logic [2:0] CFG_SKIP       = 3'd5;
    localparam logic [2:0] CFG_SEARCH_RD  = 3'd6;
    localparam logic [2:0] CFG_MEAS_RD    = 3'd7;

    typedef enum logic [1:0] {
        CMD_START, CMD_TICK, CMD_READING, CMD_UNUSED
    } in_cmd_t;

    typedef enum logic [1:0] {
        RS_VALID, RS_SATURATED, RS_OVERFLOW, RS_INVALID
    } rd_status_t;

    typedef enum logic [3:0] {
        ACT_BRIGHT, ACT_LED_ON, ACT_LED_OFF, ACT_AGC_OFF, ACT_GAIN,
        ACT_INTEG, ACT_START, ACT_STOP, ACT_ENTRY, ACT_DONE
    } act_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_INIT, PH_SEARCH, PH_PAIR_INIT,
        PH_WAIT, PH_MEASURE, PH_TABLE, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_INIT, SEQ_BRIGHT, SEQ_NEXT, SEQ_LED_OFF, SEQ_MEAS, SEQ_TABLE
    } seq_t;

    typedef enum logic [3:0] {
        CS_IDLE, CS_TICK, CS_AVG_WAIT, CS_TBL_MUL, CS_TBL_DIV,
        CS_TBL_WAIT, CS_EMIT
    } ctl_state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAPTURE, DP_INIT, DP_SEARCH, DP_PAIR_INIT, DP_DELAY_DEC,
        DP_MEAS_START, DP_AVG_START, DP_AVG_STORE, DP_TBL_INIT, DP_TBL_MUL,
        DP_TBL_DIV, DP_TBL_STORE, DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        seq_t              seq;
        logic [EMIT_W-1:0] idx;
        logic              last;
    } dp_cmd_t;

    typedef struct packed {
        logic search_ready;
        logic meas_ready;
        logic sat_or_over;
        logic search_gi_zero;
        logic delay_zero;
        logic avg_gi_zero;
        logic div_done;
        logic walk_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [EMIT_W-1:0] seq_len(seq_t s);
        logic [EMIT_W-1:0] n;
        unique case (s)
            SEQ_INIT:    n = EMIT_W'(6);
            SEQ_BRIGHT:  n = EMIT_W'(1);
            SEQ_NEXT:    n = EMIT_W'(3);
            SEQ_LED_OFF: n = EMIT_W'(1);
            SEQ_MEAS:    n = EMIT_W'(4);
            SEQ_TABLE:   n = EMIT_W'(GAIN_SLOTS + 3);
            default:     n = EMIT_W'(1);
        endcase
        return n;
    endfunction

    function automatic act_t seq_action(seq_t s, logic [EMIT_W-1:0] i);
        act_t a;
        a = ACT_DONE;
        unique case (s)
            SEQ_INIT: begin
                unique case (i)
                    EMIT_W'(0): a = ACT_BRIGHT;
                    EMIT_W'(1): a = ACT_LED_ON;
                    EMIT_W'(2): a = ACT_AGC_OFF;
                    EMIT_W'(3): a = ACT_GAIN;
                    EMIT_W'(4): a = ACT_INTEG;
                    default:    a = ACT_START;
                endcase
            end
            SEQ_BRIGHT:  a = ACT_BRIGHT;
            SEQ_NEXT: begin
                unique case (i)
                    EMIT_W'(0): a = ACT_BRIGHT;
                    EMIT_W'(1): a = ACT_GAIN;
                    default:    a = ACT_INTEG;
                endcase
            end
            SEQ_LED_OFF: a = ACT_LED_OFF;
            SEQ_MEAS: begin
                unique case (i)
                    EMIT_W'(0): a = ACT_BRIGHT;
                    EMIT_W'(1): a = ACT_LED_ON;
                    EMIT_W'(2): a = ACT_GAIN;
                    default:    a = ACT_INTEG;
                endcase
            end
            SEQ_TABLE: begin
                if (int'(i) < GAIN_SLOTS)
                    a = ACT_ENTRY;
                else if (int'(i) == GAIN_SLOTS)
                    a = ACT_LED_OFF;
                else if (int'(i) == GAIN_SLOTS + 1)
                    a = ACT_STOP;
                else
                    a = ACT_DONE;
            end
            default: a = ACT_DONE;
        endcase
        return a;
    endfunction

endpackage

@@ src/sensor_gain_calibration_sequencer_unit.sv @@
// Light-sensor gain calibration sequencer, top level. Uses sgcs_pkg, sgcs_ctrl, sgcs_datapath.
// One beat at a time: start and reading beats are handled as they are taken; a tick runs its
// step, then emits its result beats; a measurement tick also waits for the averaging divide.
// The table tick runs TOP_GAIN_INDEX ratio steps (multiply, then the 64-step serial divider),
// then emits 13 result beats, one per cycle when m_tready holds.
// Reset: synchronous, active low; clears phase, counters and configuration to defaults.
module sensor_gain_calibration_sequencer_unit
    import sgcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [1:0] reading_status, [33:2] reading_value, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] action_value, [47:32] action_aux
    output logic [3:0]  m_tuser,   // [3:0] action
    output logic        m_tlast    // last result of the input beat
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sequence the phases and issue datapath commands
    sgcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // hold state, tables, arithmetic and the output register
    sgcs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_status (s_tdata[1:0]),
        .rd_value  (s_tdata[33:2]),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ src/sgcs_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
// Depends on nothing; used by sgcs_datapath.
module sgcs_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] numer,
    input  logic [31:0] denom,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] nq_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, nq_reg[63]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            nq_reg  <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= 32'(trial - {1'b0, den_reg});
                nq_reg  <= {nq_reg[62:0], 1'b1};
            end else begin
                rem_reg <= trial[31:0];
                nq_reg  <= {nq_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

@@ src/sgcs_datapath.sv @@
// Datapath: configuration, sequence state, reading statistics, tables, divider,
// multiplier and the result register. Depends on sgcs_pkg and sgcs_div.
module sgcs_datapath
    import sgcs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic [1:0]   rd_status,
    input  logic [31:0]  rd_value,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    output logic [3:0]   m_tuser,
    output logic         m_tlast
);

    logic [31:0] limit_reg;
    logic [15:0] delay_cfg_reg, search_smp_reg, meas_smp_reg, smp_time_reg;
    logic [3:0]  skip_cfg_reg;
    logic [7:0]  search_rd_reg, meas_rd_reg;

    logic [GAIN_W-1:0]          gain_index_reg, gain_out_reg;
    logic [BRIGHTNESS_BITS-1:0] bright_reg;
    logic [3:0]                 skip_reg;
    logic [15:0]                delay_reg;
    logic                       upper_reg, capturing_reg, meas_reg;
    logic [7:0]                 cnt_reg, vcnt_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [1:0]                 lstat_reg;
    logic [31:0]                lval_reg;

    logic [BRIGHTNESS_BITS-1:0] btab_reg [GAIN_SLOTS];
    logic [31:0]                up_reg   [GAIN_SLOTS];
    logic [31:0]                lo_reg   [GAIN_SLOTS];
    logic [31:0]                tab_reg  [GAIN_SLOTS];

    logic [GAIN_W-1:0] walk_reg, dest_reg;
    logic [31:0]       base_reg, den_reg;
    logic [63:0]       prod_reg;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [15:0] out_aux_reg;
    act_t        out_act_reg;
    logic        out_last_reg;

    logic [GAIN_W-1:0]          g, gm1;
    logic                       sat;
    logic                       over;
    logic [BRIGHTNESS_BITS:0]   dbl;
    logic [BRIGHTNESS_BITS-1:0] bright_up, bright_dn;
    logic                       div_start;
    logic [63:0]                div_numer;
    logic [31:0]                div_denom;
    logic                       div_done;
    logic [63:0]                div_quot;
    logic [31:0]                ratio_q, avg_q;
    act_t                       emit_act;
    logic [31:0]                emit_value;
    logic [15:0]                emit_aux;
    logic                       out_free;

    assign g   = (int'(gain_index_reg) < GAIN_SLOTS) ? gain_index_reg
                                                      : GAIN_W'(TOP_GAIN_INDEX);
    assign gm1 = (g != '0) ? g - GAIN_W'(1) : '0;

    assign sat       = (lstat_reg == RS_SATURATED) || (lstat_reg == RS_OVERFLOW);
    assign over      = lval_reg > limit_reg;
    assign dbl       = {bright_reg, 1'b1};
    assign bright_up = dbl[BRIGHTNESS_BITS] ? BRIGHT_MAX : dbl[BRIGHTNESS_BITS-1:0];
    assign bright_dn = (bright_reg != '0) ? bright_reg - BRIGHTNESS_BITS'(1) : '0;

    assign div_start = (cmd.op == DP_AVG_START) || (cmd.op == DP_TBL_DIV);
    assign div_numer = (cmd.op == DP_AVG_START)
                     ? 64'(sum_reg) + 64'(vcnt_reg >> 1)
                     : prod_reg + 64'(den_reg >> 1);
    assign div_denom = (cmd.op == DP_AVG_START) ? 32'(vcnt_reg) : den_reg;

    sgcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign ratio_q = ((den_reg == '0) || (div_quot[63:32] != '0)) ? QMAX : div_quot[31:0];
    assign avg_q   = (vcnt_reg == '0) ? '0 : div_quot[31:0];

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        emit_act   = seq_action(cmd.seq, cmd.idx);
        emit_value = '0;
        emit_aux   = '0;
        unique case (emit_act)
            ACT_BRIGHT: emit_value = 32'(bright_reg);
            ACT_GAIN:   emit_value = 32'(gain_out_reg);
            ACT_INTEG: begin
                emit_value = 32'(meas_reg ? meas_smp_reg : search_smp_reg);
                emit_aux   = smp_time_reg;
            end
            ACT_ENTRY: begin
                emit_value = tab_reg[cmd.idx[GAIN_W-1:0]];
                emit_aux   = 16'(cmd.idx);
            end
            default: ;
        endcase
    end

    // configuration and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= 32'd1000000;
            delay_cfg_reg  <= 16'd200;
            search_smp_reg <= 16'd99;
            meas_smp_reg   <= 16'd199;
            smp_time_reg   <= 16'd719;
            skip_cfg_reg   <= 4'd2;
            search_rd_reg  <= 8'd2;
            meas_rd_reg    <= 8'd5;
            gain_index_reg <= '0;
            gain_out_reg   <= '0;
            bright_reg     <= '0;
            skip_reg       <= '0;
            delay_reg      <= '0;
            upper_reg      <= 1'b0;
            capturing_reg  <= 1'b0;
            meas_reg       <= 1'b0;
            cnt_reg        <= '0;
            vcnt_reg       <= '0;
            sum_reg        <= '0;
            lstat_reg      <= '0;
            lval_reg       <= '0;
            walk_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_LIMIT:      limit_reg      <= cfg_data;
                    CFG_DELAY:      delay_cfg_reg  <= cfg_data[15:0];
                    CFG_SEARCH_SMP: search_smp_reg <= cfg_data[15:0];
                    CFG_MEAS_SMP:   meas_smp_reg   <= cfg_data[15:0];
                    CFG_SMP_TIME:   smp_time_reg   <= cfg_data[15:0];
                    CFG_SKIP:       skip_cfg_reg   <= cfg_data[3:0];
                    CFG_SEARCH_RD:  search_rd_reg  <= cfg_data[7:0];
                    CFG_MEAS_RD:    meas_rd_reg    <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (m_tready && cmd.op != DP_EMIT)
                out_valid_reg <= 1'b0;

            unique case (cmd.op)
                DP_CAPTURE: begin
                    if (capturing_reg) begin
                        if (skip_reg != '0) begin
                            skip_reg <= skip_reg - 4'd1;
                        end else if (cnt_reg != 8'hFF) begin
                            cnt_reg   <= cnt_reg + 8'd1;
                            lstat_reg <= rd_status;
                            lval_reg  <= rd_value;
                            if (rd_status == RS_VALID) begin
                                sum_reg  <= sum_reg + SUM_W'(rd_value);
                                vcnt_reg <= vcnt_reg + 8'd1;
                            end
                        end
                    end
                end
                DP_INIT: begin
                    gain_index_reg <= GAIN_W'(TOP_GAIN_INDEX);
                    gain_out_reg   <= GAIN_W'(TOP_GAIN_INDEX);
                    bright_reg     <= '0;
                    skip_reg       <= skip_cfg_reg;
                    capturing_reg  <= 1'b1;
                    meas_reg       <= 1'b0;
                end
                DP_SEARCH: begin
                    if (sat) begin
                        bright_reg <= bright_up;
                    end else if (over) begin
                        bright_reg <= bright_dn;
                    end else begin
                        gain_index_reg <= gm1;
                        if (gm1 != '0) begin
                            bright_reg   <= '0;
                            gain_out_reg <= gm1;
                            meas_reg     <= 1'b0;
                        end
                    end
                    skip_reg  <= skip_cfg_reg;
                    cnt_reg   <= '0;
                    vcnt_reg  <= '0;
                    sum_reg   <= '0;
                    lstat_reg <= '0;
                    lval_reg  <= '0;
                end
                DP_PAIR_INIT: begin
                    capturing_reg  <= 1'b0;
                    gain_index_reg <= GAIN_W'(TOP_GAIN_INDEX);
                    skip_reg       <= skip_cfg_reg;
                    cnt_reg        <= '0;
                    vcnt_reg       <= '0;
                    sum_reg        <= '0;
                    lstat_reg      <= '0;
                    lval_reg       <= '0;
                    delay_reg      <= delay_cfg_reg;
                    upper_reg      <= 1'b1;
                end
                DP_DELAY_DEC: delay_reg <= delay_reg - 16'd1;
                DP_MEAS_START: begin
                    bright_reg    <= btab_reg[g];
                    gain_out_reg  <= upper_reg ? g : gm1;
                    meas_reg      <= 1'b1;
                    skip_reg      <= skip_cfg_reg;
                    cnt_reg       <= '0;
                    vcnt_reg      <= '0;
                    sum_reg       <= '0;
                    lstat_reg     <= '0;
                    lval_reg      <= '0;
                    capturing_reg <= 1'b1;
                end
                DP_AVG_STORE: begin
                    cnt_reg       <= '0;
                    vcnt_reg      <= '0;
                    sum_reg       <= '0;
                    lstat_reg     <= '0;
                    lval_reg      <= '0;
                    capturing_reg <= 1'b0;
                    delay_reg     <= delay_cfg_reg;
                    if (upper_reg) begin
                        upper_reg <= 1'b0;
                    end else begin
                        gain_index_reg <= gm1;
                        upper_reg      <= 1'b1;
                    end
                end
                DP_TBL_INIT:  walk_reg <= GAIN_W'(TOP_GAIN_INDEX);
                DP_TBL_STORE: walk_reg <= walk_reg - GAIN_W'(1);
                DP_EMIT:      out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // tables and arithmetic payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            DP_SEARCH: begin
                if (!sat && !over)
                    btab_reg[g] <= bright_reg;
            end
            DP_AVG_STORE: begin
                if (upper_reg)
                    up_reg[g] <= avg_q;
                else
                    lo_reg[g] <= avg_q;
            end
            DP_TBL_INIT: begin
                tab_reg[TOP_GAIN_INDEX-1] <= REF_Q16;
                base_reg                  <= REF_Q16;
            end
            DP_TBL_MUL: begin
                if (int'(walk_reg) == TOP_GAIN_INDEX) begin
                    prod_reg <= 64'(base_reg) * 64'(up_reg[walk_reg]);
                    den_reg  <= lo_reg[walk_reg];
                    dest_reg <= walk_reg;
                end else begin
                    prod_reg <= 64'(base_reg) * 64'(lo_reg[walk_reg]);
                    den_reg  <= up_reg[walk_reg];
                    dest_reg <= walk_reg - GAIN_W'(1);
                end
            end
            DP_TBL_STORE: begin
                tab_reg[dest_reg] <= ratio_q;
                if (int'(walk_reg) != TOP_GAIN_INDEX)
                    base_reg <= ratio_q;
            end
            DP_EMIT: begin
                out_act_reg   <= emit_act;
                out_value_reg <= emit_value;
                out_aux_reg   <= emit_aux;
                out_last_reg  <= cmd.last;
            end
            default: ;
        endcase
    end

    always_comb begin
        status.search_ready   = cnt_reg >= search_rd_reg;
        status.meas_ready     = cnt_reg >= meas_rd_reg;
        status.sat_or_over    = sat || over;
        status.search_gi_zero = gm1 == '0;
        status.delay_zero     = delay_reg == '0;
        status.avg_gi_zero    = upper_reg ? (gain_index_reg == '0) : (gm1 == '0);
        status.div_done       = div_done;
        status.walk_last      = walk_reg == GAIN_W'(1);
        status.out_free       = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_aux_reg, out_value_reg};
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/sgcs_ctrl.sv @@
// Controller: calibration phase, command sequencing and result emission steps.
// Depends on sgcs_pkg; drives sgcs_datapath through dp_cmd_t.
module sgcs_ctrl
    import sgcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_cmd,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    ctl_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    seq_t              seq_reg, seq_next;
    logic [EMIT_W-1:0] idx_reg, idx_next;
    logic              is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            phase_reg <= PH_IDLE;
            seq_reg   <= SEQ_BRIGHT;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            idx_reg   <= idx_next;
        end
    end

    assign is_last = idx_reg == seq_len(seq_reg) - EMIT_W'(1);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        seq_next   = seq_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.seq    = seq_reg;
        cmd.idx    = idx_reg;
        cmd.last   = 1'b0;

        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_cmd_t'(s_cmd))
                        CMD_START:   phase_next = PH_INIT;
                        CMD_TICK:    state_next = CS_TICK;
                        CMD_READING: begin
                            if (phase_reg != PH_IDLE && phase_reg != PH_DONE)
                                cmd.op = DP_CAPTURE;
                        end
                        default: ;
                    endcase
                end
            end
            CS_TICK: begin
                state_next = CS_IDLE;
                idx_next   = '0;
                unique case (phase_reg)
                    PH_INIT: begin
                        cmd.op     = DP_INIT;
                        seq_next   = SEQ_INIT;
                        phase_next = PH_SEARCH;
                        state_next = CS_EMIT;
                    end
                    PH_SEARCH: begin
                        if (status.search_ready) begin
                            cmd.op = DP_SEARCH;
                            if (status.sat_or_over) begin
                                seq_next   = SEQ_BRIGHT;
                                state_next = CS_EMIT;
                            end else if (status.search_gi_zero) begin
                                phase_next = PH_PAIR_INIT;
                            end else begin
                                seq_next   = SEQ_NEXT;
                                state_next = CS_EMIT;
                            end
                        end
                    end
                    PH_PAIR_INIT: begin
                        cmd.op     = DP_PAIR_INIT;
                        seq_next   = SEQ_LED_OFF;
                        phase_next = PH_WAIT;
                        state_next = CS_EMIT;
                    end
                    PH_WAIT: begin
                        if (!status.delay_zero) begin
                            cmd.op = DP_DELAY_DEC;
                        end else begin
                            cmd.op     = DP_MEAS_START;
                            seq_next   = SEQ_MEAS;
                            phase_next = PH_MEASURE;
                            state_next = CS_EMIT;
                        end
                    end
                    PH_MEASURE: begin
                        if (status.meas_ready) begin
                            cmd.op     = DP_AVG_START;
                            state_next = CS_AVG_WAIT;
                        end
                    end
                    PH_TABLE: begin
                        cmd.op     = DP_TBL_INIT;
                        state_next = CS_TBL_MUL;
                    end
                    default: ;
                endcase
            end
            CS_AVG_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = DP_AVG_STORE;
                    seq_next   = SEQ_LED_OFF;
                    phase_next = status.avg_gi_zero ? PH_TABLE : PH_WAIT;
                    state_next = CS_EMIT;
                end
            end
            CS_TBL_MUL: begin
                cmd.op     = DP_TBL_MUL;
                state_next = CS_TBL_DIV;
            end
            CS_TBL_DIV: begin
                cmd.op     = DP_TBL_DIV;
                state_next = CS_TBL_WAIT;
            end
            CS_TBL_WAIT: begin
                if (status.div_done) begin
                    cmd.op = DP_TBL_STORE;
                    if (status.walk_last) begin
                        seq_next   = SEQ_TABLE;
                        phase_next = PH_DONE;
                        state_next = CS_EMIT;
                    end else begin
                        state_next = CS_TBL_MUL;
                    end
                end
            end
            CS_EMIT: begin
                if (status.out_free) begin
                    cmd.op   = DP_EMIT;
                    cmd.last = is_last;
                    idx_next = idx_reg + EMIT_W'(1);
                    if (is_last)
                        state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for the gain calibration sequencer: drives command, tick and
// reading beats, predicts every result beat in a scoreboard and compares them.
// Depends on sgcs_pkg and sensor_gain_calibration_sequencer_unit.
`timescale 1ns / 100ps

module tb_top;
    import sgcs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 800;   // covers the table walk after the last beat

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // [1:0] reading_status, [33:2] reading_value, rest zero
    logic [1:0]  s_tuser;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [31:0] action_value, [47:32] action_aux
    logic [3:0]  m_tuser;    // [3:0] action
    logic        m_tlast;

    sensor_gain_calibration_sequencer_unit dut (.*);

    // Scoreboard: its own model of the sequencer plus the queue of result beats
    // still owed by the block.
    class cal_scoreboard;
        typedef struct {
            act_t        act;
            logic [31:0] val;
            logic [15:0] aux;
            logic        last;
        } result_t;

        result_t     owed[$];
        int          errors;
        // registers
        logic [31:0] limit;
        logic [15:0] delay_cfg, search_smp, meas_smp, smp_time;
        logic [3:0]  skip_cfg;
        logic [7:0]  search_rd, meas_rd;
        // sequence state
        phase_t      ph;
        int unsigned gi;
        logic [7:0]  bright;
        logic [3:0]  skip_left;
        logic [15:0] delay_left;
        bit          upper, capturing;
        logic [7:0]  captured, vcount;
        logic [39:0] vsum;
        logic [1:0]  lstat;
        logic [31:0] lval;
        logic [7:0]  btab[GAIN_SLOTS];
        logic [31:0] uavg[GAIN_SLOTS];
        logic [31:0] lavg[GAIN_SLOTS];

        function new();
            errors = 0;
            limit = 1000000; delay_cfg = 200; search_smp = 99; meas_smp = 199;
            smp_time = 719; skip_cfg = 2; search_rd = 2; meas_rd = 5;
            ph = PH_IDLE; gi = 0; bright = 0; skip_left = 0; delay_left = 0;
            upper = 0; capturing = 0;
            clear_list();
            foreach (btab[i]) begin
                btab[i] = 0; uavg[i] = 0; lavg[i] = 0;
            end
        endfunction

        function void clear_list();
            captured = 0; vsum = 0; vcount = 0; lstat = 0; lval = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                CFG_LIMIT:      limit      = d;
                CFG_DELAY:      delay_cfg  = d[15:0];
                CFG_SEARCH_SMP: search_smp = d[15:0];
                CFG_MEAS_SMP:   meas_smp   = d[15:0];
                CFG_SMP_TIME:   smp_time   = d[15:0];
                CFG_SKIP:       skip_cfg   = d[3:0];
                CFG_SEARCH_RD:  search_rd  = d[7:0];
                default:        meas_rd    = d[7:0];
            endcase
        endfunction

        function void owe(act_t a, logic [31:0] v, logic [15:0] x);
            result_t r;
            r.act = a; r.val = v; r.aux = x; r.last = 0;
            owed.push_back(r);
        endfunction

        // rounded Q16.16 quotient base*num/den, saturating
        function logic [63:0] ratio(logic [63:0] base, logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            if (den == 0)
                return 64'(QMAX);
            q = (base * num + den / 2) / den;
            return (q > 64'(QMAX)) ? 64'(QMAX) : q;
        endfunction

        function void tick();
            int unsigned g, nb;
            logic [31:0] avg;
            logic [63:0] tab[GAIN_SLOTS];
            g = (gi < GAIN_SLOTS) ? gi : TOP_GAIN_INDEX;
            case (ph)
                PH_INIT: begin
                    gi = TOP_GAIN_INDEX; bright = 0; skip_left = skip_cfg;
                    owe(ACT_BRIGHT, 0, 0);
                    owe(ACT_LED_ON, 0, 0);
                    owe(ACT_AGC_OFF, 0, 0);
                    owe(ACT_GAIN, gi, 0);
                    owe(ACT_INTEG, search_smp, smp_time);
                    owe(ACT_START, 0, 0);
                    capturing = 1;
                    ph = PH_SEARCH;
                end
                PH_SEARCH: begin
                    if (captured >= search_rd) begin
                        if (lstat == RS_SATURATED || lstat == RS_OVERFLOW) begin
                            nb = 2 * bright + 1;
                            bright = (nb > BRIGHT_MAX) ? BRIGHT_MAX : nb[7:0];
                            owe(ACT_BRIGHT, bright, 0);
                        end else if (lval > limit) begin
                            if (bright > 0)
                                bright--;
                            owe(ACT_BRIGHT, bright, 0);
                        end else begin
                            btab[g] = bright;
                            gi = (g > 0) ? g - 1 : 0;
                            if (gi == 0) begin
                                ph = PH_PAIR_INIT;
                            end else begin
                                bright = 0;
                                owe(ACT_BRIGHT, 0, 0);
                                owe(ACT_GAIN, gi, 0);
                                owe(ACT_INTEG, search_smp, smp_time);
                            end
                        end
                        skip_left = skip_cfg;
                        clear_list();
                    end
                end
                PH_PAIR_INIT: begin
                    capturing = 0; gi = TOP_GAIN_INDEX; skip_left = skip_cfg;
                    clear_list();
                    owe(ACT_LED_OFF, 0, 0);
                    delay_left = delay_cfg; upper = 1;
                    ph = PH_WAIT;
                end
                PH_WAIT: begin
                    if (delay_left > 0) begin
                        delay_left--;
                    end else begin
                        bright = btab[g];
                        owe(ACT_BRIGHT, bright, 0);
                        owe(ACT_LED_ON, 0, 0);
                        owe(ACT_GAIN, upper ? g : ((g > 0) ? g - 1 : 0), 0);
                        owe(ACT_INTEG, meas_smp, smp_time);
                        skip_left = skip_cfg;
                        clear_list();
                        capturing = 1;
                        ph = PH_MEASURE;
                    end
                end
                PH_MEASURE: begin
                    if (captured >= meas_rd) begin
                        avg = 0;
                        if (vcount > 0)
                            avg = 32'((vsum + 40'(vcount / 2)) / 40'(vcount));
                        if (upper)
                            uavg[g] = avg;
                        else
                            lavg[g] = avg;
                        owe(ACT_LED_OFF, 0, 0);
                        clear_list();
                        capturing = 0; delay_left = delay_cfg;
                        if (upper) begin
                            upper = 0;
                        end else begin
                            gi = (g > 0) ? g - 1 : 0;
                            upper = 1;
                        end
                        ph = (gi == 0) ? PH_TABLE : PH_WAIT;
                    end
                end
                PH_TABLE: begin
                    // chain the ratios down from the fixed 128.0 entry
                    tab[TOP_GAIN_INDEX-1] = 64'(REF_Q16);
                    tab[TOP_GAIN_INDEX] = ratio(64'(REF_Q16), uavg[TOP_GAIN_INDEX],
                                                lavg[TOP_GAIN_INDEX]);
                    for (int i = TOP_GAIN_INDEX - 1; i > 0; i--)
                        tab[i-1] = ratio(tab[i], lavg[i], uavg[i]);
                    for (int i = 0; i < GAIN_SLOTS; i++)
                        owe(ACT_ENTRY, tab[i][31:0], 16'(i));
                    owe(ACT_LED_OFF, 0, 0);
                    owe(ACT_STOP, 0, 0);
                    owe(ACT_DONE, 0, 0);
                    ph = PH_DONE;
                end
                default: ;
            endcase
        endfunction

        function void note_input(in_cmd_t c, rd_status_t s, logic [31:0] v);
            int n0;
            n0 = owed.size();
            case (c)
                CMD_START: ph = PH_INIT;
                CMD_TICK: begin
                    tick();
                    if (owed.size() > n0)
                        owed[owed.size()-1].last = 1;
                end
                CMD_READING: begin
                    if (ph >= PH_INIT && ph <= PH_TABLE && capturing) begin
                        if (skip_left > 0) begin
                            skip_left--;
                        end else if (captured < 255) begin
                            captured++;
                            lstat = s; lval = v;
                            if (s == RS_VALID) begin
                                vsum += 40'(v);
                                vcount++;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(act_t a, logic [31:0] v, logic [15:0] x, logic l);
            result_t e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: action %0d value %0h aux %0h last %0b",
                             a, v, x, l);
                return;
            end
            e = owed.pop_front();
            if (e.act !== a || e.val !== v || e.aux !== x || e.last !== l) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected act %0d val %0h aux %0h last %0b, got %0d %0h %0h %0b",
                             e.act, e.val, e.aux, e.last, a, v, x, l);
            end
        endfunction
    endclass

    cal_scoreboard sb;
    int unsigned   cycles;
    bit            hold_req;

    // 12 ns clock
    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // check every accepted result beat at the clock edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(act_t'(m_tuser), m_tdata[31:0], m_tdata[47:32], m_tlast);
    end

    // mostly zero gaps, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_tready = 1'b0;
                    repeat (n) @(negedge aclk);
                end
                m_tready = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // present one beat and hold it until the block takes it
    task automatic send(in_cmd_t c, rd_status_t s, logic [31:0] v);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = c;
        s_tdata  = {6'b0, v, s};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(c, s, v);
    endtask

    task automatic sender_gap();
        int n;
        n = pick_gap();
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // drop valid and let every owed result drain, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
        @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_index = idx; cfg_data = d;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, d);
    endtask

    task automatic set_cfg(logic [31:0] lim, logic [15:0] dly, logic [15:0] ssmp,
                           logic [15:0] msmp, logic [15:0] stime, logic [3:0] skip,
                           logic [7:0] srd, logic [7:0] mrd);
        drain();
        cfg_write(CFG_LIMIT, lim);
        cfg_write(CFG_DELAY, dly);
        cfg_write(CFG_SEARCH_SMP, ssmp);
        cfg_write(CFG_MEAS_SMP, msmp);
        cfg_write(CFG_SMP_TIME, stime);
        cfg_write(CFG_SKIP, skip);
        cfg_write(CFG_SEARCH_RD, srd);
        cfg_write(CFG_MEAS_RD, mrd);
    endtask

    task automatic rand_reading(output rd_status_t s, output logic [31:0] v);
        int r;
        r = $urandom_range(0, 99);
        s = (r < 70) ? RS_VALID : (r < 80) ? RS_SATURATED : (r < 88) ? RS_OVERFLOW : RS_INVALID;
        r = $urandom_range(0, 99);
        if (r < 10)
            v = r[0] ? 32'hFFFF_FFFF : 32'h0;
        else if (r < 70)
            v = $urandom_range(0, sb.limit);
        else
            v = $urandom;
    endtask

    // mostly well-formed calibration traffic steered by the model state,
    // with a sprinkle of stray commands
    task automatic run_calibration(int budget);
        int         n, r, need;
        in_cmd_t    c;
        rd_status_t s;
        logic [31:0] v;
        send(CMD_START, RS_VALID, 0);
        n = 0;
        while (n < budget && sb.ph != PH_DONE) begin
            r = $urandom_range(0, 99);
            need = (sb.ph == PH_SEARCH) ? sb.search_rd : sb.meas_rd;
            if (r == 0)
                c = CMD_START;
            else if (r < 6)
                c = in_cmd_t'($urandom_range(1, 3));
            else if (sb.capturing && (sb.ph == PH_SEARCH || sb.ph == PH_MEASURE) &&
                     (sb.skip_left > 0 || sb.captured < need))
                c = CMD_READING;
            else
                c = CMD_TICK;
            rand_reading(s, v);
            send(c, s, v);
            sender_gap();
            n++;
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_req = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // directed: stray commands while idle, then one search step of each kind
        send(CMD_TICK, RS_VALID, 32'h1234);
        send(CMD_READING, RS_SATURATED, 32'hFFFF_FFFF);
        send(CMD_UNUSED, RS_INVALID, 32'hFFFF_FFFF);
        send(CMD_START, RS_VALID, 0);
        send(CMD_TICK, RS_VALID, 0);
        send(CMD_READING, RS_VALID, 32'hFFFF_FFFF);   // skipped
        send(CMD_READING, RS_SATURATED, 0);           // skipped
        send(CMD_READING, RS_SATURATED, 0);
        send(CMD_TICK, RS_VALID, 0);                  // not enough readings yet
        send(CMD_READING, RS_OVERFLOW, 32'hFFFF_FFFF);
        send(CMD_TICK, RS_VALID, 0);                  // brightness doubles
        send(CMD_READING, RS_VALID, 5);
        send(CMD_READING, RS_VALID, 5);
        send(CMD_READING, RS_INVALID, 7);
        send(CMD_READING, RS_VALID, 32'hFFFF_FFFF);
        send(CMD_TICK, RS_VALID, 0);                  // above limit: step down
        send(CMD_READING, RS_VALID, 0);
        send(CMD_READING, RS_VALID, 0);
        send(CMD_READING, RS_VALID, 0);
        send(CMD_READING, RS_INVALID, 0);
        send(CMD_TICK, RS_VALID, 0);                  // store, move to next gain
        send(CMD_START, RS_VALID, 0);                 // restart mid-sequence
        send(CMD_UNUSED, RS_INVALID, 32'hAAAA_5555);

        // long receiver hold-off while the sender keeps pushing
        set_cfg(1000000, 0, 99, 199, 719, 0, 1, 1);
        hold_req = 1;
        run_calibration(110);
        // all-ones extremes, every reading under the limit
        set_cfg(32'hFFFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15, 1, 2);
        run_calibration(20);
        // zero extremes: decisions on an empty list, zero averages, division by zero
        set_cfg(0, 0, 0, 0, 0, 0, 0, 0);
        run_calibration(55);
        // long reading lists
        set_cfg($urandom, 0, 16'($urandom), 16'($urandom), 16'($urandom), 1, 255, 255);
        run_calibration(5);
        // mixed random settings
        repeat (2) begin
            set_cfg($urandom, 16'($urandom_range(0, 4)), 16'($urandom), 16'($urandom),
                    16'($urandom), 4'($urandom_range(0, 3)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 6)));
            run_calibration(8);
        end
        // longest LED-off delay, never waited out
        set_cfg(1000000, 16'hFFFF, 1, 1, 1, 0, 1, 1);
        run_calibration(3);

        drain();
        if (sb.owed.size() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
